/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define SBS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define SBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sbs_pkg.sv */
// Types and constants of the sparse band statistics block.
package sbs_pkg;

  localparam int unsigned ENTRY_W  = 24;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIV_CNT_W = $clog2(ACC_W);

  typedef enum logic [1:0] {
    MODE_MAX  = 2'd0,
    MODE_MEAN = 2'd1,
    MODE_MIN  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_e;

  typedef struct packed {
    logic accumulate;
    logic load_direct;
    logic div_start;
    logic div_step;
    logic load_quot;
  } cmd_t;

  typedef struct packed {
    logic mean;
    logic div_last;
  } status_t;

endpackage

/* hw/rtl/sbs_ifs.sv */
// Stream interfaces for table entries and band results.
interface sbs_entry_if;
  import sbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] row_index;
  logic [ENTRY_W-1:0] col_index;
  logic               row_last;
  logic               matrix_last;

  modport source (output valid, row_index, col_index, row_last, matrix_last, input ready);
  modport sink   (input valid, row_index, col_index, row_last, matrix_last, output ready);
endinterface

interface sbs_result_if;
  import sbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] band_value;

  modport source (output valid, band_value, input ready);
  modport sink   (input valid, band_value, output ready);
endinterface

/* hw/rtl/sbs_divider.sv */
// Restoring divider, one quotient bit per cycle while step_i is high, for the mean band.
module sbs_divider import sbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               step_i,
  input  logic [ACC_W-1:0]   dividend_i,
  input  logic [ENTRY_W-1:0] divisor_i,
  output logic [ACC_W-1:0]   quot_next_o,
  output logic               last_o
);

  logic [ENTRY_W-1:0]   rem_q, rem_d;
  logic [ACC_W-1:0]     quo_q, quo_d;
  logic [ENTRY_W-1:0]   div_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ENTRY_W:0]     shifted;
  logic [ENTRY_W+1:0]   trial;
  logic                 fits;

  always_comb begin
    shifted = {rem_q, quo_q[ACC_W-1]};
    trial   = {1'b0, shifted} - {2'b00, div_q};
    fits    = ~trial[ENTRY_W+1];
    rem_d   = fits ? trial[ENTRY_W-1:0] : shifted[ENTRY_W-1:0];
    quo_d   = {quo_q[ACC_W-2:0], fits};
    cnt_d   = cnt_q + DIV_CNT_W'(1);
  end

  assign quot_next_o = quo_d;
  assign last_o      = (cnt_q == DIV_CNT_W'(ACC_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule

/* hw/rtl/sbs_datapath.sv */
// Distance, accumulator, configuration and result datapath.
module sbs_datapath import sbs_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ENTRY_W-1:0]    row_index_i,
  input  logic [ENTRY_W-1:0]    col_index_i,
  input  logic                  row_last_i,
  input  logic                  matrix_last_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic [ENTRY_W-1:0]    band_value_o
);

  localparam int unsigned EffW = (INDEX_WIDTH < ENTRY_W) ? INDEX_WIDTH : ENTRY_W;
  localparam logic [ENTRY_W-1:0] IdxMask = ENTRY_W'((33'(1) << EffW) - 33'(1));

  mode_e              mode_q;
  logic [ENTRY_W-1:0] rows_q;
  logic [ACC_W-1:0]   acc_q;
  logic [ENTRY_W-1:0] rmax_q;
  logic               started_q;
  logic [ENTRY_W-1:0] band_q;

  logic [ENTRY_W-1:0] row_m, col_m, dist_abs, rmax_upd, rmax_new, divisor;
  logic [ACC_W-1:0]   dist_w, acc_base, acc_upd, acc_new, quot_next;
  logic [ACC_W:0]     sum;
  logic               skip, row_close, div_last;
  logic [ENTRY_W-1:0] direct_val, quot_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MAX;
      rows_q <= ENTRY_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BAND_MODE: mode_q <= mode_e'(cfg_data_i[1:0]);
        CFG_NUM_ROWS:  rows_q <= cfg_data_i[ENTRY_W-1:0];
        default:       mode_q <= mode_q;
      endcase
    end
  end

  always_comb begin
    row_m    = row_index_i & IdxMask;
    col_m    = col_index_i & IdxMask;
    skip     = (row_m == col_m);
    dist_abs = (row_m > col_m) ? (row_m - col_m) : (col_m - row_m);
    dist_w   = {{(ACC_W-ENTRY_W){1'b0}}, dist_abs};
    acc_base = started_q ? acc_q
             : ((mode_q == MODE_MIN) ? {{(ACC_W-ENTRY_W){1'b0}}, rows_q} : '0);
    acc_upd  = acc_base;
    rmax_upd = rmax_q;
    case (mode_q)
      MODE_MAX:  if (!skip && dist_w > acc_base) acc_upd = dist_w;
      MODE_MIN:  if (!skip && dist_w < acc_base) acc_upd = dist_w;
      MODE_MEAN: if (!skip && dist_abs > rmax_q) rmax_upd = dist_abs;
      default:   acc_upd = acc_base;
    endcase
    row_close = row_last_i | matrix_last_i;
    sum       = {1'b0, acc_base} + {{(ACC_W-ENTRY_W+1){1'b0}}, rmax_upd};
    acc_new   = acc_upd;
    if (row_close && mode_q == MODE_MEAN) begin
      acc_new = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    end
    rmax_new  = row_close ? '0 : rmax_upd;
    // Max and min modes report the accumulator, saturated; other modes report zero here.
    if (mode_q == MODE_MAX || mode_q == MODE_MIN) begin
      direct_val = (|acc_new[ACC_W-1:ENTRY_W]) ? '1 : acc_new[ENTRY_W-1:0];
    end else begin
      direct_val = '0;
    end
    divisor  = (rows_q == '0) ? ENTRY_W'(1) : rows_q;
    quot_val = (|quot_next[ACC_W-1:ENTRY_W]) ? '1 : quot_next[ENTRY_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      rmax_q    <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.accumulate) begin
      if (matrix_last_i) begin
        acc_q     <= '0;
        rmax_q    <= '0;
        started_q <= 1'b0;
      end else begin
        acc_q     <= acc_new;
        rmax_q    <= rmax_new;
        started_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_direct) begin
      band_q <= direct_val;
    end else if (cmd_i.load_quot) begin
      band_q <= quot_val;
    end
  end

  sbs_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .step_i      (cmd_i.div_step),
    .dividend_i  (acc_new),
    .divisor_i   (divisor),
    .quot_next_o (quot_next),
    .last_o      (div_last)
  );

  assign status_o.mean     = (mode_q == MODE_MEAN);
  assign status_o.div_last = div_last;
  assign band_value_o      = band_q;

endmodule

/* hw/rtl/sbs_ctrl.sv */
// Controller: entry acceptance, mean division sequencing, result valid.
module sbs_ctrl import sbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  input  logic    out_ready_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_ready, fire;

  always_comb begin
    in_ready          = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
    fire              = in_valid_i && in_ready;
    cmd_o.accumulate  = fire;
    cmd_o.load_direct = fire && in_last_i && !status_i.mean;
    cmd_o.div_start   = fire && in_last_i && status_i.mean;
    cmd_o.div_step    = (state_q == ST_DIV);
    cmd_o.load_quot   = (state_q == ST_DIV) && status_i.div_last;

    case (state_q)
      ST_RUN:  state_d = cmd_o.div_start ? ST_DIV : ST_RUN;
      ST_DIV:  state_d = status_i.div_last ? ST_RUN : ST_DIV;
      default: state_d = ST_RUN;
    endcase

    if (cmd_o.load_direct || cmd_o.load_quot) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/sparse_band_statistics_top.sv */
// Max, min and unknown modes give the result in the cycle after the last entry.
// Mean mode runs a bit-serial division after the last entry.
// One entry per cycle; the 48-step divider stalls input once per mean-mode matrix.
// Input also waits while a finished result has not been taken.
// Reset (rst_ni low, asynchronous) sets mode to maximum, row count to 1, clears state.
// Top level of the sparse matrix band statistics block.
module sparse_band_statistics_top import sbs_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sbs_entry_if.sink             entry_i,
  sbs_result_if.source          result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Commands flow from the controller to the datapath; status flows back.
  cmd_t    cmd;
  status_t status;

  // The controller owns the handshakes. An entry transfer happens while the
  // controller runs and the result register is free or being emptied.
  sbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (entry_i.valid),
    .in_last_i   (entry_i.matrix_last),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .in_ready_o  (entry_i.ready),
    .out_valid_o (result_o.valid),
    .cmd_o       (cmd)
  );

  // The datapath folds every accepted entry into the running band statistic
  // and holds the result register and the mean divider.
  sbs_datapath #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .row_index_i   (entry_i.row_index),
    .col_index_i   (entry_i.col_index),
    .row_last_i    (entry_i.row_last),
    .matrix_last_i (entry_i.matrix_last),
    .cmd_i         (cmd),
    .status_o      (status),
    .band_value_o  (result_o.band_value)
  );

endmodule

/* hw/rtl/sbs_checker.sv */
// Port-level assertions for the sparse band statistics block, with bind.
`include "assert_macros.svh"

module sbs_checker import sbs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_last,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ENTRY_W-1:0]    band_value,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [1:0] mode_q;
  logic       in_fire, last_mean, last_other;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MAX;
    end else if (cfg_we_i && cfg_index_i == CFG_BAND_MODE) begin
      mode_q <= cfg_data_i[1:0];
    end
  end

  assign in_fire    = in_valid && in_ready;
  assign last_mean  = in_fire && in_last && (mode_q == MODE_MEAN);
  assign last_other = in_fire && in_last && (mode_q != MODE_MEAN);

  `SBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(band_value), "result changed before its transfer")
  `SBS_ASSERT_SAME(a_no_entry_when_blocked, clk_i, rst_ni, out_valid && !out_ready, !in_ready, "entry taken while result waits")
  `SBS_ASSERT_NEXT(a_direct_result, clk_i, rst_ni, last_other, out_valid, "no result after last entry")
  `SBS_ASSERT_NEXT(a_mean_stall, clk_i, rst_ni, last_mean, !in_ready && !out_valid, "mean division did not stall")

endmodule

bind sparse_band_statistics_top sbs_checker u_sbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (entry_i.valid),
  .in_ready    (entry_i.ready),
  .in_last     (entry_i.matrix_last),
  .out_valid   (result_o.valid),
  .out_ready   (result_o.ready),
  .band_value  (result_o.band_value),
  .cfg_we_i    (cfg_we_i),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);

/* verif/tb_top.sv */
// Self-checking testbench of the sparse band statistics block: directed and random tables.
`timescale 1ns / 1ps

module tb_top;
  import sbs_pkg::*;

  localparam int unsigned MAX_INDEX    = 24'hFF_FFFF;
  localparam int unsigned TARGET_ITEMS = 1420;
  localparam int unsigned SETTLE_CYC   = 4;
  localparam int unsigned TAIL_CYC     = 64;
  localparam int unsigned HOLD_CYC     = 300;
  localparam int unsigned HOLD_PHASE   = 4;
  localparam int unsigned REPORT_LIMIT = 10;

  // Predicts the band value of each table and checks it against the block's output.
  class band_checker;
    mode_e                mode;
    logic [ENTRY_W-1:0]   num_rows;
    logic [ACC_W-1:0]     band_acc;
    logic [ENTRY_W-1:0]   row_max;
    bit                   started;
    logic [ENTRY_W-1:0]   expected_bands[$];
    int unsigned          mismatches;

    function new();
      mode     = MODE_MAX;
      num_rows = 1;
      band_acc = '0;
      row_max  = '0;
      started  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BAND_MODE) begin
        mode = mode_e'(data[1:0]);
      end else begin
        num_rows = data[ENTRY_W-1:0];
      end
    endfunction

    function int unsigned pending();
      return expected_bands.size();
    endfunction

    function void note_entry(logic [ENTRY_W-1:0] row, logic [ENTRY_W-1:0] col,
                             logic row_end, logic last);
      logic [ENTRY_W-1:0] distance;
      logic [ACC_W:0]     sum;
      logic [ACC_W-1:0]   divisor;
      logic [ACC_W-1:0]   band;
      // The start value is chosen by the mode in force at the first entry.
      if (!started) begin
        band_acc = (mode == MODE_MIN) ? ACC_W'(num_rows) : '0;
        row_max  = '0;
        started  = 1'b1;
      end
      // Diagonal and padding entries carry no distance.
      if (row != col) begin
        distance = (row > col) ? row - col : col - row;
        case (mode)
          MODE_MAX:  if (distance > band_acc) band_acc = ACC_W'(distance);
          MODE_MIN:  if (distance < band_acc) band_acc = ACC_W'(distance);
          MODE_MEAN: if (distance > row_max) row_max = distance;
          default: ;
        endcase
      end
      // The last entry of the table also closes its row.
      if (row_end || last) begin
        if (mode == MODE_MEAN) begin
          sum = band_acc + row_max;
          band_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        end
        row_max = '0;
      end
      if (last) begin
        case (mode)
          MODE_MEAN: begin
            divisor = (num_rows == 0) ? ACC_W'(1) : ACC_W'(num_rows);
            band = band_acc / divisor;
          end
          MODE_MAX, MODE_MIN: band = band_acc;
          default: band = '0;
        endcase
        expected_bands.push_back((band > MAX_INDEX) ? ENTRY_W'(MAX_INDEX) : band[ENTRY_W-1:0]);
        band_acc = '0;
        row_max  = '0;
        started  = 1'b0;
      end
    endfunction

    function void check_band(logic [ENTRY_W-1:0] actual);
      logic [ENTRY_W-1:0] wanted;
      if (expected_bands.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("band result 0x%06h arrived with no table pending", actual);
      end else begin
        wanted = expected_bands.pop_front();
        if (actual !== wanted) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("band mismatch: expected 0x%06h, got 0x%06h", wanted, actual);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sbs_entry_if  entry_bus ();
  sbs_result_if result_bus ();

  band_checker bands = new();

  int unsigned items_sent;
  int unsigned burst_left;
  bit          hold_req;

  sparse_band_statistics_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (entry_bus),
    .result_o   (result_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Every result transfer is checked against the oldest predicted band.
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      bands.check_band(result_bus.band_value);
    end
  end

  // Receiver: switches between stall patterns, and holds off once for a long
  // stretch when asked so that the block fills up and stalls its input.
  initial begin
    int unsigned cyc;
    int unsigned pattern;
    logic        rdy;
    result_bus.ready = 1'b0;
    cyc = 0;
    pattern = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (cyc % 64 == 0) pattern = $urandom_range(0, 3);
        case (pattern)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = (cyc % 8) < 5;
        endcase
        result_bus.ready <= rdy;
        cyc++;
      end
    end
  end

  // Hard limit on the run; far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Offers one entry and waits for its transfer.
  task automatic send_entry(input logic [ENTRY_W-1:0] row, input logic [ENTRY_W-1:0] col,
                            input logic row_end, input logic last);
    @(negedge clk_i);
    entry_bus.valid       <= 1'b1;
    entry_bus.row_index   <= row;
    entry_bus.col_index   <= col;
    entry_bus.row_last    <= row_end;
    entry_bus.matrix_last <= last;
    do @(posedge clk_i); while (!entry_bus.ready);
    bands.note_entry(row, col, row_end, last);
    items_sent++;
  endtask

  task automatic sender_gap(input int unsigned cycles);
    @(negedge clk_i);
    entry_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Sends in bursts of random length with random gaps between them.
  task automatic offer_entry(input logic [ENTRY_W-1:0] row, input logic [ENTRY_W-1:0] col,
                             input logic row_end, input logic last);
    send_entry(row, col, row_end, last);
    burst_left--;
    if (burst_left == 0) begin
      sender_gap($urandom_range(0, 8));
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Waits until every predicted band has arrived and the block has settled.
  task automatic drain_and_settle();
    sender_gap(0);
    while (bands.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    bands.set_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [ENTRY_W-1:0] pick_col(logic [ENTRY_W-1:0] row);
    logic [ENTRY_W-1:0] offset;
    offset = ($urandom_range(0, 5) == 0) ? ENTRY_W'($urandom) : ENTRY_W'($urandom_range(0, 64));
    case ($urandom_range(0, 9))
      0, 1: return row;
      2: return ENTRY_W'($urandom);
      3: return '0;
      4: return ENTRY_W'(MAX_INDEX);
      5, 6: return row + offset;
      default: return row - offset;
    endcase
  endfunction

  // A well-formed table: rows in sequence, each closed by its row end flag or the last flag.
  task automatic send_matrix();
    int unsigned        nrows;
    int unsigned        per_row;
    logic [ENTRY_W-1:0] row;
    logic               row_end;
    logic               last;
    nrows = $urandom_range(1, 4);
    row = ($urandom_range(0, 3) == 0) ? ENTRY_W'($urandom) : ENTRY_W'($urandom_range(0, 200));
    for (int unsigned r = 0; r < nrows; r++) begin
      per_row = $urandom_range(1, 4);
      for (int unsigned e = 0; e < per_row; e++) begin
        row_end = (e == per_row - 1);
        last    = row_end && (r == nrows - 1);
        if (last && $urandom_range(0, 7) == 0) row_end = 1'b0;
        offer_entry(row, pick_col(row), row_end, last);
      end
      row++;
    end
  endtask

  // Broken sequences: random flags, which may leave a table open.
  task automatic send_noise();
    int unsigned        count;
    logic [ENTRY_W-1:0] row;
    count = $urandom_range(1, 6);
    for (int unsigned e = 0; e < count; e++) begin
      row = ENTRY_W'($urandom);
      offer_entry(row, pick_col(row), 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_num_rows();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 1;
      2: return CFG_DATA_W'(MAX_INDEX);
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned nmat;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = CFG_BAND_MODE;
    cfg_data_i            = '0;
    entry_bus.valid       = 1'b0;
    entry_bus.row_index   = '0;
    entry_bus.col_index   = '0;
    entry_bus.row_last    = 1'b0;
    entry_bus.matrix_last = 1'b0;
    items_sent = 0;
    burst_left = $urandom_range(1, 30);
    hold_req   = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: maximum band, one row. Widest possible distance.
    offer_entry('0, ENTRY_W'(MAX_INDEX), 1'b1, 1'b1);
    // Diagonal entries are skipped; the largest distance is 3.
    offer_entry(5, 5, 1'b0, 1'b0);
    offer_entry(5, 3, 1'b1, 1'b0);
    offer_entry(6, 9, 1'b0, 1'b0);
    offer_entry(6, 6, 1'b1, 1'b1);

    // Minimum band: a table of only diagonal entries returns the row count.
    drain_and_settle();
    cfg_write(CFG_BAND_MODE, CFG_DATA_W'(MODE_MIN));
    cfg_write(CFG_NUM_ROWS, CFG_DATA_W'(MAX_INDEX));
    offer_entry(ENTRY_W'(MAX_INDEX), ENTRY_W'(MAX_INDEX), 1'b1, 1'b1);
    offer_entry(10, 12, 1'b0, 1'b0);
    offer_entry(11, 11, 1'b1, 1'b1);

    // Mean band with one row: the sum exceeds the output range and saturates.
    // The last entry also ends its row without the row end flag.
    drain_and_settle();
    cfg_write(CFG_BAND_MODE, CFG_DATA_W'(MODE_MEAN));
    cfg_write(CFG_NUM_ROWS, 1);
    offer_entry('0, ENTRY_W'(MAX_INDEX), 1'b1, 1'b0);
    offer_entry(ENTRY_W'(MAX_INDEX), '0, 1'b0, 1'b1);

    // A row count of zero divides as if it were one.
    drain_and_settle();
    cfg_write(CFG_NUM_ROWS, 0);
    offer_entry(3, 1, 1'b1, 1'b0);
    offer_entry(4, 8, 1'b1, 1'b1);

    // Ordinary truncated mean over three rows, one of them empty.
    drain_and_settle();
    cfg_write(CFG_NUM_ROWS, 3);
    offer_entry(1, 4, 1'b0, 1'b0);
    offer_entry(1, 2, 1'b1, 1'b0);
    offer_entry(2, 2, 1'b1, 1'b0);
    offer_entry(3, 0, 1'b0, 1'b1);

    // The unknown mode always gives zero.
    drain_and_settle();
    cfg_write(CFG_BAND_MODE, CFG_DATA_W'(MODE_NONE));
    offer_entry(1, 7, 1'b1, 1'b1);

    // Mode and row count change in the middle of one table.
    drain_and_settle();
    cfg_write(CFG_BAND_MODE, CFG_DATA_W'(MODE_MIN));
    cfg_write(CFG_NUM_ROWS, 100);
    offer_entry(20, 25, 1'b1, 1'b0);
    drain_and_settle();
    cfg_write(CFG_BAND_MODE, CFG_DATA_W'(MODE_MAX));
    offer_entry(0, 40, 1'b1, 1'b0);
    drain_and_settle();
    cfg_write(CFG_BAND_MODE, CFG_DATA_W'(MODE_MEAN));
    cfg_write(CFG_NUM_ROWS, 4);
    offer_entry(9, 1, 1'b1, 1'b0);
    offer_entry(2, 3, 1'b1, 1'b1);

    // Random phases, each under its own register setting. One phase runs
    // against the long receiver hold-off.
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      drain_and_settle();
      cfg_write(CFG_BAND_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      cfg_write(CFG_NUM_ROWS, pick_num_rows());
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      nmat = (phase == HOLD_PHASE) ? 6 : $urandom_range(1, 6);
      for (int unsigned m = 0; m < nmat; m++) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_matrix();
      end
      phase++;
    end

    // Drain, then leave room for a late or extra result to show up.
    sender_gap(0);
    while (bands.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (bands.mismatches == 0 && bands.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
